[rtl/lpeg_pkg.sv]
`timescale 1ns / 1ps
package lpeg_pkg;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;

	typedef enum logic [2:0] {
		REG_COMPONENT = 3'd0,
		REG_A1        = 3'd1,
		REG_A11       = 3'd2,
		REG_A12       = 3'd3,
		REG_A111      = 3'd4,
		REG_A112      = 3'd5,
		REG_A123      = 3'd6
	} reg_idx_t;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;
	localparam logic [1:0] AXIS_OTHER = 2'd3;
endpackage

[rtl/lpeg_qmul.sv]
`timescale 1ns / 1ps
// Registered fixed-point multiply: round half away from zero, saturate.
module lpeg_qmul #(
	parameter int DW = 32,
	parameter int SH = 16
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [DW-1:0] a,
	input  logic signed [DW-1:0] b,
	output logic signed [DW-1:0] p
);
	logic signed [2*DW-1:0] prod;
	logic        [2*DW-1:0] mag;
	logic        [2*DW:0]   rnd;
	logic        [2*DW:0]   shf;
	logic                   neg;
	logic signed [DW-1:0]   res;
	localparam logic [2*DW:0] HALF = (SH > 0) ? ((2*DW+1)'(1) << (SH > 0 ? SH-1 : 0))
		: '0;
	localparam logic [2*DW:0] LIM = (2*DW+1)'({1'b0, {(DW-1){1'b1}}});

	always_comb begin
		prod = $signed({{DW{a[DW-1]}}, a}) * $signed({{DW{b[DW-1]}}, b});
		neg  = a[DW-1] ^ b[DW-1];
		mag  = prod[2*DW-1] ? (2*DW)'(-prod) : prod;
		rnd  = {1'b0, mag} + HALF;
		shf  = rnd >> SH;
		if (neg) begin
			res = (shf > LIM + 1) ? {1'b1, {(DW-1){1'b0}}} : DW'(-shf);
		end else begin
			res = (shf > LIM) ? {1'b0, {(DW-1){1'b1}}} : DW'(shf);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p <= res;
		end
	end
endmodule

[rtl/lpeg_qadd.sv]
`timescale 1ns / 1ps
// Registered saturating add.
module lpeg_qadd #(
	parameter int DW = 32
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [DW-1:0] a,
	input  logic signed [DW-1:0] b,
	output logic signed [DW-1:0] s
);
	logic signed [DW:0] sum;
	logic signed [DW-1:0] res;

	always_comb begin
		sum = {a[DW-1], a} + {b[DW-1], b};
		if (sum[DW] != sum[DW-1]) begin
			res = sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end else begin
			res = sum[DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s <= res;
		end
	end
endmodule

[rtl/landau_polarization_energy_gradient.sv]
`timescale 1ns / 1ps
// Throughput: one transaction per cycle; a stall freezes the whole pipeline.
// Each stage holds at most one multiply or one saturating add per term.
// Reset (arst_n low) clears valid bits and config registers; data needs none.
module landau_polarization_energy_gradient #(
	parameter int DATA_WIDTH = lpeg_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = lpeg_pkg::FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [DATA_WIDTH-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// pol_x, pol_y, pol_z, test_value, shape_value, coupled_axis, zero fill
	input  logic [((5*DATA_WIDTH+2+7)/8)*8-1:0] s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// residual, diag_jacobian, offdiag_jacobian, zero fill
	output logic [((3*DATA_WIDTH+7)/8)*8-1:0] m_tdata
);
	import lpeg_pkg::*;

	localparam int DW = DATA_WIDTH;
	localparam int NS = 20;
	localparam int DL = 11;
	localparam int OW = ((3*DW+7)/8)*8;
	typedef logic signed [DW-1:0] w_t;

	// Config registers
	logic [1:0] comp_q;
	w_t a1_q, a11_q, a12_q, a111_q, a112_q, a123_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_q <= '0;
			a1_q <= '0; a11_q <= '0; a12_q <= '0;
			a111_q <= '0; a112_q <= '0; a123_q <= '0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_COMPONENT: comp_q <= cfg_data[1:0];
				REG_A1:        a1_q   <= cfg_data;
				REG_A11:       a11_q  <= cfg_data;
				REG_A12:       a12_q  <= cfg_data;
				REG_A111:      a111_q <= cfg_data;
				REG_A112:      a112_q <= cfg_data;
				REG_A123:      a123_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Scaled coefficients, computed from static config (exact n*a, saturated)
	function automatic w_t ksat(input int n, input w_t a);
		logic signed [DW+5:0] t;
		begin
			t = (DW+6)'(n) * {{6{a[DW-1]}}, a};
			if (t > (DW+6)'($signed({1'b0, {(DW-1){1'b1}}})))
				ksat = {1'b0, {(DW-1){1'b1}}};
			else if (t < -(DW+6)'($signed({1'b0, {(DW-1){1'b1}}})) - 1)
				ksat = {1'b1, {(DW-1){1'b0}}};
			else
				ksat = t[DW-1:0];
		end
	endfunction

	w_t k2a1_q, k4a11_q, k12a11_q, k2a12_q, k4a12_q, k6a111_q, k30a111_q;
	w_t k2a112_q, k4a112_q, k8a112_q, k12a112_q, k2a123_q, k4a123_q;
	always_ff @(posedge clk) begin
		k2a1_q   <= ksat(2, a1_q);
		k4a11_q  <= ksat(4, a11_q);
		k12a11_q <= ksat(12, a11_q);
		k2a12_q  <= ksat(2, a12_q);
		k4a12_q  <= ksat(4, a12_q);
		k6a111_q <= ksat(6, a111_q);
		k30a111_q <= ksat(30, a111_q);
		k2a112_q <= ksat(2, a112_q);
		k4a112_q <= ksat(4, a112_q);
		k8a112_q <= ksat(8, a112_q);
		k12a112_q <= ksat(12, a112_q);
		k2a123_q <= ksat(2, a123_q);
		k4a123_q <= ksat(4, a123_q);
	end

	// Valid chain; advance all stages together when output can move
	logic [NS-1:0] vld_q;
	logic en;
	assign en = !vld_q[NS-1] || m_tready;
	assign s_tready = en;
	assign m_tvalid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NS-2:0], s_tvalid};
		end
	end

	// Stage 1: register input with the axis selection
	w_t px, py, pz;
	assign px = s_tdata[DW-1:0];
	assign py = s_tdata[2*DW-1:DW];
	assign pz = s_tdata[3*DW-1:2*DW];
	logic [1:0] ci;
	assign ci = (comp_q > AXIS_Z) ? AXIS_Z : comp_q;

	w_t pi_s1, pj_s1, pk_s1, pc_s1, pr_s1, tst_s1, shp_s1;
	logic offen_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			case (ci)
				AXIS_X:  begin pi_s1 <= px; pj_s1 <= py; pk_s1 <= pz; end
				AXIS_Y:  begin pi_s1 <= py; pj_s1 <= pz; pk_s1 <= px; end
				default: begin pi_s1 <= pz; pj_s1 <= px; pk_s1 <= py; end
			endcase
			// coupled c and remaining r
			case (s_tdata[5*DW+1:5*DW])
				AXIS_X:  pc_s1 <= px;
				AXIS_Y:  pc_s1 <= py;
				default: pc_s1 <= pz;
			endcase
			case (2'(3 - ci - s_tdata[5*DW+1:5*DW]))
				AXIS_X:  pr_s1 <= px;
				AXIS_Y:  pr_s1 <= py;
				default: pr_s1 <= pz;
			endcase
			offen_s1 <= (s_tdata[5*DW+1:5*DW] != AXIS_OTHER)
				&& (s_tdata[5*DW+1:5*DW] != ci);
			tst_s1 <= s_tdata[4*DW-1:3*DW];
			shp_s1 <= s_tdata[5*DW-1:4*DW];
		end
	end

	// Delay line for pass-through values; index d = value at stage d+1
	w_t pi_d[1:DL-1], pc_d[1:DL-1], tst_d[1:DL-1], shp_d[1:DL-1];
	logic off_d[1:DL-1];
	always_ff @(posedge clk) begin
		if (en) begin
			pi_d[1] <= pi_s1; pc_d[1] <= pc_s1; tst_d[1] <= tst_s1;
			shp_d[1] <= shp_s1; off_d[1] <= offen_s1;
			for (int d = 2; d < DL; d++) begin
				pi_d[d] <= pi_d[d-1]; pc_d[d] <= pc_d[d-1];
				tst_d[d] <= tst_d[d-1]; shp_d[d] <= shp_d[d-1];
				off_d[d] <= off_d[d-1];
			end
		end
	end

	// Helper macro-like instances. Stage numbers: output of an op feeding
	// stage n+1 is "_sN+1". Stage 2
	w_t i2, j2, k2, c2, r2, da, ja, tb;
	lpeg_qmul #(DW, FRAC_BITS) u_i2 (clk, en, pi_s1, pi_s1, i2);
	lpeg_qmul #(DW, FRAC_BITS) u_j2 (clk, en, pj_s1, pj_s1, j2);
	lpeg_qmul #(DW, FRAC_BITS) u_k2 (clk, en, pk_s1, pk_s1, k2);
	lpeg_qmul #(DW, FRAC_BITS) u_c2 (clk, en, pc_s1, pc_s1, c2);
	lpeg_qmul #(DW, FRAC_BITS) u_r2 (clk, en, pr_s1, pr_s1, r2);
	lpeg_qmul #(DW, FRAC_BITS) u_da (clk, en, k2a1_q, pi_s1, da);   // 2a1 Pi
	lpeg_qmul #(DW, FRAC_BITS) u_ja (clk, en, k2a12_q, pi_s1, ja);  // 2a12 Pi
	lpeg_qmul #(DW, FRAC_BITS) u_tb (clk, en, k4a12_q, pi_s1, tb);  // 4a12 Pi
	w_t db, dc, t1a, t4a;
	lpeg_qmul #(DW, FRAC_BITS) u_db (clk, en, k2a112_q, pi_s1, db); // 2a112 Pi
	lpeg_qmul #(DW, FRAC_BITS) u_dc (clk, en, k2a123_q, pi_s1, dc); // 2a123 Pi
	lpeg_qmul #(DW, FRAC_BITS) u_t3 (clk, en, k8a112_q, pi_s1, t1a);// 8a112 Pi
	lpeg_qmul #(DW, FRAC_BITS) u_t4 (clk, en, k4a123_q, pi_s1, t4a);// 4a123 Pi

	// Stage 3
	w_t i3, i4, s3, jj4, kk4, jk, c3, tA, tD1, d_i2m;
	lpeg_qmul #(DW, FRAC_BITS) u_i3 (clk, en, i2, pi_d[1], i3);
	lpeg_qmul #(DW, FRAC_BITS) u_i4 (clk, en, i2, i2, i4);
	lpeg_qadd #(DW) u_s (clk, en, j2, k2, s3);
	lpeg_qmul #(DW, FRAC_BITS) u_j4 (clk, en, j2, j2, jj4);
	lpeg_qmul #(DW, FRAC_BITS) u_k4 (clk, en, k2, k2, kk4);
	lpeg_qmul #(DW, FRAC_BITS) u_jk (clk, en, j2, k2, jk);
	lpeg_qmul #(DW, FRAC_BITS) u_c3 (clk, en, c2, pc_d[1], c3);
	lpeg_qmul #(DW, FRAC_BITS) u_tA (clk, en, tb, pc_d[1], tA);     // 4a12 Pi Pc
	lpeg_qmul #(DW, FRAC_BITS) u_tD1 (clk, en, t4a, pc_d[1], tD1);  // 4a123 Pi Pc
	lpeg_qmul #(DW, FRAC_BITS) u_jb (clk, en, k12a11_q, i2, d_i2m); // 12a11 i2
	w_t r2_3, da3, ja3, db3, dc3, t1a3, i2_3;
	always_ff @(posedge clk) begin
		if (en) begin
			r2_3 <= r2; da3 <= da; ja3 <= ja; db3 <= db; dc3 <= dc;
			t1a3 <= t1a; i2_3 <= i2;
		end
	end

	// Stage 4
	w_t i5, q4, dt2, dt3, jt4, jt5, jt7, tB, tC, tD, jt6p;
	lpeg_qmul #(DW, FRAC_BITS) u_i5 (clk, en, i4, pi_d[2], i5);
	lpeg_qadd #(DW) u_q (clk, en, jj4, kk4, q4);
	lpeg_qmul #(DW, FRAC_BITS) u_d2 (clk, en, k4a11_q, i3, dt2);
	lpeg_qmul #(DW, FRAC_BITS) u_d3 (clk, en, ja3, s3, dt3);
	lpeg_qmul #(DW, FRAC_BITS) u_j3 (clk, en, k2a12_q, s3, jt4);     // j term3
	lpeg_qmul #(DW, FRAC_BITS) u_j4t (clk, en, k30a111_q, i4, jt5);  // j term4
	lpeg_qmul #(DW, FRAC_BITS) u_j7 (clk, en, k2a123_q, jk, jt7);    // j term7
	lpeg_qmul #(DW, FRAC_BITS) u_tB0 (clk, en, k8a112_q, i3, tB);    // 8a112 i3
	lpeg_qmul #(DW, FRAC_BITS) u_tC (clk, en, t1a3, c3, tC);         // 8a112 Pi Pc^3
	lpeg_qmul #(DW, FRAC_BITS) u_tD (clk, en, tD1, r2_3, tD);
	lpeg_qmul #(DW, FRAC_BITS) u_j6p (clk, en, k12a112_q, i2_3, jt6p);
	w_t d4a, d4b, d4e, s4, jb4, tA4, db3_4;
	lpeg_qmul #(DW, FRAC_BITS) u_d4e (clk, en, k4a112_q, i3, d4e);   // 4a112 i3
	lpeg_qmul #(DW, FRAC_BITS) u_d7 (clk, en, dc3, jk, d4b);         // d term7
	always_ff @(posedge clk) begin
		if (en) begin
			d4a <= da3; s4 <= s3; jb4 <= d_i2m; tA4 <= tA; db3_4 <= db3;
		end
	end

	// Stage 5
	w_t dt4, dt5, dt6, jt6, jt8, tB5, ds1, js1;
	lpeg_qmul #(DW, FRAC_BITS) u_d4 (clk, en, k6a111_q, i5, dt4);
	lpeg_qmul #(DW, FRAC_BITS) u_d5 (clk, en, d4e, s4, dt5);
	lpeg_qmul #(DW, FRAC_BITS) u_d6 (clk, en, db3_4, q4, dt6);
	lpeg_qmul #(DW, FRAC_BITS) u_j6 (clk, en, jt6p, s4, jt6);
	lpeg_qmul #(DW, FRAC_BITS) u_j8 (clk, en, k2a112_q, q4, jt8);
	lpeg_qmul #(DW, FRAC_BITS) u_tB (clk, en, tB, pc_d[3], tB5);
	lpeg_qadd #(DW) u_ds1 (clk, en, d4a, dt2, ds1);
	lpeg_qadd #(DW) u_js1 (clk, en, k2a1_q, jb4, js1);
	w_t dt3_5, d7_5, jt4_5, jt5_5, jt7_5, tA5, tC5, tD5;
	always_ff @(posedge clk) begin
		if (en) begin
			dt3_5 <= dt3; d7_5 <= d4b; jt4_5 <= jt4; jt5_5 <= jt5;
			jt7_5 <= jt7; tA5 <= tA4; tC5 <= tC; tD5 <= tD;
		end
	end

	// Stage 6..: serial saturating sums, in model order
	w_t ds2, js2, to2;
	lpeg_qadd #(DW) u_ds2 (clk, en, ds1, dt3_5, ds2);
	lpeg_qadd #(DW) u_js2 (clk, en, js1, jt4_5, js2);
	lpeg_qadd #(DW) u_to2 (clk, en, tA5, tB5, to2);
	w_t dt4_6, dt5_6, dt6_6, d7_6, jt5_6, jt6_6, jt8_6, jt7_6, tC6, tD6;
	always_ff @(posedge clk) begin
		if (en) begin
			dt4_6 <= dt4; dt5_6 <= dt5; dt6_6 <= dt6; d7_6 <= d7_5;
			jt5_6 <= jt5_5; jt6_6 <= jt6; jt8_6 <= jt8; jt7_6 <= jt7_5;
			tC6 <= tC5; tD6 <= tD5;
		end
	end
	// Stage 7
	w_t ds3, js3, to3;
	lpeg_qadd #(DW) u_ds3 (clk, en, ds2, dt4_6, ds3);
	lpeg_qadd #(DW) u_js3 (clk, en, js2, jt5_6, js3);
	lpeg_qadd #(DW) u_to3 (clk, en, to2, tC6, to3);
	w_t dt5_7, dt6_7, d7_7, jt6_7, jt8_7, jt7_7, tD7;
	always_ff @(posedge clk) begin
		if (en) begin
			dt5_7 <= dt5_6; dt6_7 <= dt6_6; d7_7 <= d7_6;
			jt6_7 <= jt6_6; jt8_7 <= jt8_6; jt7_7 <= jt7_6; tD7 <= tD6;
		end
	end
	// Stage 8
	w_t ds4, js4, to4;
	lpeg_qadd #(DW) u_ds4 (clk, en, ds3, dt5_7, ds4);
	lpeg_qadd #(DW) u_js4 (clk, en, js3, jt6_7, js4);
	lpeg_qadd #(DW) u_to4 (clk, en, to3, tD7, to4);
	w_t dt6_8, d7_8, jt8_8, jt7_8;
	always_ff @(posedge clk) begin
		if (en) begin
			dt6_8 <= dt6_7; d7_8 <= d7_7; jt8_8 <= jt8_7; jt7_8 <= jt7_7;
		end
	end
	// Stage 9
	w_t ds5, js5, to5;
	lpeg_qadd #(DW) u_ds5 (clk, en, ds4, dt6_8, ds5);
	lpeg_qadd #(DW) u_js5 (clk, en, js4, jt8_8, js5);
	lpeg_qmul #(DW, FRAC_BITS) u_to5 (clk, en, to4, tst_d[7], to5);
	w_t d7_9, jt7_9;
	always_ff @(posedge clk) begin
		if (en) begin
			d7_9 <= d7_8; jt7_9 <= jt7_8;
		end
	end
	// Stage 10
	w_t ds6, js6, to6;
	lpeg_qadd #(DW) u_ds6 (clk, en, ds5, d7_9, ds6);
	lpeg_qadd #(DW) u_js6 (clk, en, js5, jt7_9, js6);
	lpeg_qmul #(DW, FRAC_BITS) u_to6 (clk, en, to5, shp_d[8], to6);
	// Stage 11
	w_t res11, jt11, to11;
	lpeg_qmul #(DW, FRAC_BITS) u_res (clk, en, ds6, tst_d[9], res11);
	lpeg_qmul #(DW, FRAC_BITS) u_jtt (clk, en, js6, tst_d[9], jt11);
	always_ff @(posedge clk) begin
		if (en) to11 <= off_d[9] ? to6 : '0;
	end
	// Stage 12
	w_t res12, jac12, to12;
	lpeg_qmul #(DW, FRAC_BITS) u_jts (clk, en, jt11, shp_d[10], jac12);
	always_ff @(posedge clk) begin
		if (en) begin
			res12 <= res11; to12 <= to11;
		end
	end

	// Align to the last stage
	w_t r_d[1:NS-12], j_d[1:NS-12], o_d[1:NS-12];
	always_ff @(posedge clk) begin
		if (en) begin
			r_d[1] <= res12; j_d[1] <= jac12; o_d[1] <= to12;
			for (int d = 2; d <= NS-12; d++) begin
				r_d[d] <= r_d[d-1]; j_d[d] <= j_d[d-1]; o_d[d] <= o_d[d-1];
			end
		end
	end

	assign m_tdata = OW'({o_d[NS-12], j_d[NS-12], r_d[NS-12]});
endmodule

[rtl/lpeg_checker.sv]
`timescale 1ns / 1ps
module lpeg_checker (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready
);
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready) else $error("ready low with empty output");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready) else $error("accept during stall");
endmodule

bind landau_polarization_energy_gradient lpeg_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready)
);

[test/landau_polarization_energy_gradient_tb.sv]
`timescale 1ns / 1ps
module landau_polarization_energy_gradient_tb;
	import lpeg_pkg::*;

	localparam int DW = 32;
	localparam int FB = 16;
	localparam longint QMAX = 64'sd2147483647;
	localparam longint QMIN = -64'sd2147483648;
	localparam logic [31:0] ONE_Q = 32'h0001_0000;

	// one quadrature point as it enters the block
	typedef struct {
		logic [31:0] px, py, pz, test, shape;
		logic [1:0]  coupled;
	} point_t;

	// residual and the two Jacobian terms as they leave the block
	typedef struct {
		logic [31:0] res, diag, off;
	} grad_t;

	// directed vector: typed expectations hold only under the reset coefficients
	typedef struct {
		point_t pt;
		logic   typed;
		grad_t  want;
	} vector_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [DW-1:0] cfg_data;
	logic s_tvalid;
	logic s_tready;
	// pol_x, pol_y, pol_z, test_value, shape_value, coupled_axis, zero fill
	logic [167:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	// residual, diag_jacobian, offdiag_jacobian, zero fill
	logic [95:0] m_tdata;

	landau_polarization_energy_gradient dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	// shadow copy of the block's configuration
	logic [1:0] axis_reg;
	longint coef [1:6];

	grad_t expected_grads[$];
	int mismatches;
	int burst_left;
	int rx_mode;
	int rx_count;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// generous ceiling on the whole run
	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	// round(a*b / 2^sh), ties away from zero, clamped to the 32-bit signed range
	function automatic longint mul_round(longint a, longint b, int sh);
		logic neg;
		logic [127:0] ua, ub, p;
		neg = (a < 0) != (b < 0);
		ua = (a < 0) ? 128'(-a) : 128'(a);
		ub = (b < 0) ? 128'(-b) : 128'(b);
		p = ua * ub;
		if (sh > 0)
			p = (p + (128'd1 << (sh - 1))) >> sh;
		if (p > 128'(QMAX))
			return neg ? QMIN : QMAX;
		return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return mul_round(a, b, FB);
	endfunction

	function automatic longint kscale(longint n, longint a);
		return mul_round(n, a, 0);
	endfunction

	function automatic longint sat_add(longint a, longint b);
		longint s;
		s = a + b;
		if (s > QMAX) return QMAX;
		if (s < QMIN) return QMIN;
		return s;
	endfunction

	function automatic grad_t energy_gradient(point_t pt);
		longint p [0:2];
		longint tst, shp, pi, pj, pk, i2, i3, i4, i5, j2, k2, s, q, jk, d, jac, off;
		longint pc, pr, c2, c3, r2, t;
		int ci, cj, ck, cc;
		grad_t g;
		p[0] = longint'(signed'(pt.px));
		p[1] = longint'(signed'(pt.py));
		p[2] = longint'(signed'(pt.pz));
		tst = longint'(signed'(pt.test));
		shp = longint'(signed'(pt.shape));
		cc = pt.coupled;
		ci = (axis_reg > AXIS_Z) ? 2 : axis_reg;
		cj = (ci + 1) % 3;
		ck = (ci + 2) % 3;
		pi = p[ci];
		pj = p[cj];
		pk = p[ck];
		i2 = qmul(pi, pi);
		i3 = qmul(i2, pi);
		i4 = qmul(i2, i2);
		i5 = qmul(i4, pi);
		j2 = qmul(pj, pj);
		k2 = qmul(pk, pk);
		s = sat_add(j2, k2);
		q = sat_add(qmul(j2, j2), qmul(k2, k2));
		jk = qmul(j2, k2);

		d = qmul(kscale(2, coef[REG_A1]), pi);
		d = sat_add(d, qmul(kscale(4, coef[REG_A11]), i3));
		d = sat_add(d, qmul(qmul(kscale(2, coef[REG_A12]), pi), s));
		d = sat_add(d, qmul(kscale(6, coef[REG_A111]), i5));
		d = sat_add(d, qmul(qmul(kscale(4, coef[REG_A112]), i3), s));
		d = sat_add(d, qmul(qmul(kscale(2, coef[REG_A112]), pi), q));
		d = sat_add(d, qmul(qmul(kscale(2, coef[REG_A123]), pi), jk));

		jac = kscale(2, coef[REG_A1]);
		jac = sat_add(jac, qmul(kscale(12, coef[REG_A11]), i2));
		jac = sat_add(jac, qmul(kscale(2, coef[REG_A12]), s));
		jac = sat_add(jac, qmul(kscale(30, coef[REG_A111]), i4));
		jac = sat_add(jac, qmul(qmul(kscale(12, coef[REG_A112]), i2), s));
		jac = sat_add(jac, qmul(kscale(2, coef[REG_A112]), q));
		jac = sat_add(jac, qmul(kscale(2, coef[REG_A123]), jk));

		// coupling to the own axis or to a foreign variable contributes nothing
		off = 0;
		if (cc != AXIS_OTHER && cc != ci) begin
			pc = p[cc];
			pr = p[3 - ci - cc];
			c2 = qmul(pc, pc);
			c3 = qmul(c2, pc);
			r2 = qmul(pr, pr);
			t = qmul(qmul(kscale(4, coef[REG_A12]), pi), pc);
			t = sat_add(t, qmul(qmul(kscale(8, coef[REG_A112]), i3), pc));
			t = sat_add(t, qmul(qmul(kscale(8, coef[REG_A112]), pi), c3));
			t = sat_add(t, qmul(qmul(qmul(kscale(4, coef[REG_A123]), pi), pc), r2));
			off = qmul(qmul(t, tst), shp);
		end

		g.res = 32'(qmul(d, tst));
		g.diag = 32'(qmul(qmul(jac, tst), shp));
		g.off = 32'(off);
		return g;
	endfunction

	// mix full-range words with small and unit-scale magnitudes
	function automatic logic [31:0] rand_q();
		logic [31:0] v;
		case ($urandom_range(0, 4))
			0: v = $urandom;
			1, 2: v = $urandom_range(0, 32'h0002_0000);
			3: v = $urandom_range(0, 1024);
			default: begin
				case ($urandom_range(0, 3))
					0: v = 32'h7fff_ffff;
					1: v = 32'h8000_0000;
					2: v = ONE_Q;
					default: v = 32'h0;
				endcase
			end
		endcase
		if (v != 32'h8000_0000 && v != 32'h7fff_ffff && $urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	// call at a rising edge; returns at the edge where the transaction is taken
	task automatic send_point(point_t pt, logic typed, grad_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, pt.coupled, pt.shape, pt.test, pt.pz, pt.py, pt.px};
		do @(posedge clk); while (!s_tready);
		burst_left--;
		expected_grads.push_back(typed ? want : energy_gradient(pt));
	endtask

	// hold off until every outstanding result has been taken
	task automatic drain();
		s_tvalid <= 1'b0;
		while (expected_grads.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	// write all registers back to back while the pipeline is empty
	task automatic program_regs(logic [1:0] axis, longint c1, longint c11, longint c12,
			longint c111, longint c112, longint c123);
		logic [31:0] vals [0:6];
		vals[REG_COMPONENT] = 32'(axis);
		vals[REG_A1] = 32'(c1);
		vals[REG_A11] = 32'(c11);
		vals[REG_A12] = 32'(c12);
		vals[REG_A111] = 32'(c111);
		vals[REG_A112] = 32'(c112);
		vals[REG_A123] = 32'(c123);
		for (int r = 0; r <= 6; r++) begin
			cfg_we <= 1'b1;
			cfg_index <= 3'(r);
			cfg_data <= vals[r];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		axis_reg = axis;
		for (int r = 1; r <= 6; r++)
			coef[r] = longint'(signed'(vals[r]));
	endtask

	function automatic longint rand_coef();
		longint v;
		v = $urandom_range(0, 4 << FB);
		return $urandom_range(0, 1) ? -v : v;
	endfunction

	// result side: check each transaction against the oldest prediction
	always @(posedge clk) begin
		rx_count <= rx_count + 1;
		if (rx_count % 50 == 0)
			rx_mode <= $urandom_range(0, 2);
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 9) < 7);
			default: m_tready <= (rx_count % 5 < 2);
		endcase
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_grads.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result transaction %h", m_tdata);
			end else begin
				grad_t w;
				w = expected_grads.pop_front();
				if (m_tdata[31:0] !== w.res || m_tdata[63:32] !== w.diag ||
						m_tdata[95:64] !== w.off) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch res %h/%h diag %h/%h off %h/%h (exp/got)",
							w.res, m_tdata[31:0], w.diag, m_tdata[63:32],
							w.off, m_tdata[95:64]);
				end
			end
		end
	end

	vector_t vectors [16];

	initial begin
		point_t pt;
		grad_t zero_g;
		int n;
		zero_g = '{32'h0, 32'h0, 32'h0};
		// extremes of every field, each coupled axis, rounding ties
		vectors[0] = '{'{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, AXIS_X}, 1'b1, zero_g};
		vectors[1] = '{'{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
			32'h7fff_ffff, AXIS_OTHER}, 1'b1, zero_g};
		vectors[2] = '{'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, AXIS_X}, 1'b1, zero_g};
		vectors[3] = '{'{ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, AXIS_Y}, 1'b1, zero_g};
		vectors[4] = '{'{-ONE_Q, ONE_Q, -ONE_Q, ONE_Q, -ONE_Q, AXIS_Z}, 1'b1, zero_g};
		vectors[5] = '{'{32'h0000_8000, 32'h0000_8000, 32'hffff_8000, ONE_Q, ONE_Q,
			AXIS_X}, 1'b1, zero_g};
		vectors[6] = '{'{32'h0000_0001, 32'hffff_ffff, 32'h0000_0100, 32'h0000_00ff,
			32'hffff_ff01, AXIS_Y}, 1'b1, zero_g};
		vectors[7] = '{'{32'h0002_0000, 32'hfffe_0000, 32'h0001_8000, ONE_Q,
			32'h0000_8000, AXIS_Z}, 1'b1, zero_g};
		vectors[8] = '{'{32'h7fff_ffff, 32'h8000_0000, 32'h0, ONE_Q, ONE_Q, AXIS_OTHER},
			1'b1, zero_g};
		vectors[9] = '{'{32'h0000_c000, 32'h0001_4000, 32'hfffe_c000, 32'h0003_0000,
			32'hfffd_0000, AXIS_X}, 1'b1, zero_g};
		vectors[10] = '{'{32'h0010_0000, 32'h0010_0000, 32'h0010_0000, ONE_Q, ONE_Q,
			AXIS_Y}, 1'b1, zero_g};
		vectors[11] = '{'{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
			32'h5555_5555, AXIS_Z}, 1'b1, zero_g};
		vectors[12] = '{'{32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555,
			32'haaaa_aaaa, AXIS_OTHER}, 1'b1, zero_g};
		vectors[13] = '{'{ONE_Q, 32'h0, 32'h0, ONE_Q, ONE_Q, AXIS_X}, 1'b1, zero_g};
		vectors[14] = '{'{32'h0, ONE_Q, 32'h0, ONE_Q, ONE_Q, AXIS_Y}, 1'b1, zero_g};
		vectors[15] = '{'{32'h0, 32'h0, ONE_Q, ONE_Q, ONE_Q, AXIS_Z}, 1'b1, zero_g};

		// drive every input to a known level before reset releases
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 3'(REG_COMPONENT);
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		mismatches = 0;
		burst_left = 0;
		rx_mode = 0;
		rx_count = 0;
		axis_reg = AXIS_X;
		for (int r = 1; r <= 6; r++)
			coef[r] = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset coefficients are zero, so every directed result must be zero
		foreach (vectors[i])
			send_point(vectors[i].pt, vectors[i].typed, vectors[i].want);
		drain();

		// walk the settings: saturating extremes first, then realistic coefficients
		for (int ph = 1; ph <= 9; ph++) begin
			if (ph == 1)
				program_regs(AXIS_X, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX);
			else if (ph == 2)
				program_regs(AXIS_Y, QMIN, QMIN, QMIN, QMIN, QMIN, QMIN);
			else if (ph == 3)
				program_regs(AXIS_OTHER, 0, 0, 0, 0, 0, 0);
			else
				program_regs(2'(ph % 4), rand_coef(), rand_coef(), rand_coef(),
					rand_coef(), rand_coef(), rand_coef());
			if (ph == 1 || ph == 4) begin
				foreach (vectors[i])
					send_point(vectors[i].pt, 1'b0, zero_g);
			end
			n = (ph == 3) ? 40 : 110;
			for (int k = 0; k < n; k++) begin
				pt.px = rand_q();
				pt.py = rand_q();
				pt.pz = rand_q();
				pt.test = rand_q();
				pt.shape = rand_q();
				pt.coupled = 2'($urandom_range(0, 3));
				send_point(pt, 1'b0, zero_g);
			end
			drain();
		end

		// let any stray result surface before the verdict
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_grads.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
